FILE: rtl/ecpg_pkg.sv
// ----------------------------------------------------------------------------
// ecpg_pkg: shared types and constants
// Fixed-point widths, curve and register codes, exp2 coefficient table.
// ----------------------------------------------------------------------------
package ecpg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_BITS  = 10;
  localparam int EASE_BITS = FRAC_BITS + 1;
  localparam int STEP_BITS = 16;
  localparam int CURVE_BITS = 4;

  localparam logic [EASE_BITS-1:0] FIX_ONE  = EASE_BITS'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] FIX_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    REG_START_POS  = 2'd0,
    REG_END_POS    = 2'd1,
    REG_PHASE_STEP = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  typedef enum logic [CURVE_BITS-1:0] {
    CRV_LINEAR      = 4'd0,
    CRV_IN_QUAD     = 4'd1,
    CRV_OUT_QUAD    = 4'd2,
    CRV_INOUT_QUAD  = 4'd3,
    CRV_IN_CUBIC    = 4'd4,
    CRV_OUT_CUBIC   = 4'd5,
    CRV_INOUT_CUBIC = 4'd6,
    CRV_IN_QUART    = 4'd7,
    CRV_OUT_QUART   = 4'd8,
    CRV_IN_EXPO     = 4'd9,
    CRV_OUT_EXPO    = 4'd10,
    CRV_IN_QUINT    = 4'd11,
    CRV_OUT_QUINT   = 4'd12,
    CRV_INOUT_QUINT = 4'd13
  } curve_t;

  // configuration values handed from the front to the back
  typedef struct packed {
    logic [POS_BITS-1:0] start_pos;
    logic [POS_BITS-1:0] end_pos;
  } span_t;

  // integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r  = '0;
    b  = 64'd1 << 62;
    vv = v;
    for (int i = 0; i < 32; i++) begin
      if (vv >= r + b) begin
        vv = vv - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // entry j holds 2^(-2^-(j+1)) in Q0.32
  function automatic logic [FRAC_BITS-1:0][31:0] build_coefs();
    logic [FRAC_BITS-1:0][31:0] tab;
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int j = 0; j < FRAC_BITS; j++) begin
      c = isqrt64(c << 32);
      tab[j] = c[31:0];
    end
    return tab;
  endfunction

  localparam logic [FRAC_BITS-1:0][31:0] EXP_COEF = build_coefs();

endpackage

FILE: rtl/ecpg_queue.sv
// ----------------------------------------------------------------------------
// ecpg_queue: two-entry phase queue
// Decouples tick acceptance from curve evaluation.
// ----------------------------------------------------------------------------
module ecpg_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [ecpg_pkg::FRAC_BITS-1:0] push_data,
  input  logic                          pop,
  output logic [ecpg_pkg::FRAC_BITS-1:0] pop_data,
  output logic                          full,
  output logic                          empty
);

  logic [ecpg_pkg::FRAC_BITS-1:0] mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/ecpg_front.sv
// ----------------------------------------------------------------------------
// ecpg_front: tick intake and phase accumulator
// Holds the configuration registers, advances the phase, queues it.
// ----------------------------------------------------------------------------
module ecpg_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           tick,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [ecpg_pkg::FRAC_BITS-1:0] q_data,
  output ecpg_pkg::span_t                span
);

  logic [ecpg_pkg::FRAC_BITS-1:0] phase;
  logic [ecpg_pkg::STEP_BITS-1:0] phase_step;
  logic [ecpg_pkg::FRAC_BITS:0]   sum;
  logic                           accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~q_full;
  assign accept    = in_valid & in_ready;
  assign sum       = {1'b0, phase} + {1'b0, phase_step};
  assign q_data    = sum[ecpg_pkg::FRAC_BITS] ? '0 : sum[ecpg_pkg::FRAC_BITS-1:0];
  assign q_push    = accept & tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= '0;
      phase_step     <= 16'd328;
      span.start_pos <= 10'd10;
      span.end_pos   <= 10'd990;
    end else begin
      if (q_push) phase <= q_data;
      if (cfg_valid) begin
        case (ecpg_pkg::cfg_reg_t'(cfg_index))
          ecpg_pkg::REG_START_POS:  span.start_pos <= cfg_data[ecpg_pkg::POS_BITS-1:0];
          ecpg_pkg::REG_END_POS:    span.end_pos   <= cfg_data[ecpg_pkg::POS_BITS-1:0];
          ecpg_pkg::REG_PHASE_STEP: phase_step     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/ecpg_back.sv
// ----------------------------------------------------------------------------
// ecpg_back: curve evaluation sequencer
// Shared multiplier forms powers and exp2 terms, then emits fourteen words.
// ----------------------------------------------------------------------------
module ecpg_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  logic [ecpg_pkg::FRAC_BITS-1:0]  q_data,
  output logic                            q_pop,
  input  ecpg_pkg::span_t                 span,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ecpg_pkg::CURVE_BITS-1:0] curve,
  output logic [ecpg_pkg::EASE_BITS-1:0]  eased,
  output logic [ecpg_pkg::POS_BITS-1:0]   position,
  output logic                            last
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_POW    = 7'b0000010,
    ST_EXP    = 7'b0000100,
    ST_EXPFIN = 7'b0001000,
    ST_SEL    = 7'b0010000,
    ST_POS    = 7'b0100000,
    ST_HOLD   = 7'b1000000
  } state_t;

  localparam int EB = ecpg_pkg::EASE_BITS;

  state_t state;
  logic [ecpg_pkg::FRAC_BITS-1:0] t;
  logic [EB-1:0]  u;
  logic [EB-1:0]  pw [8];
  logic [EB-1:0]  ex [2];
  logic [2:0]     step;
  logic [3:0]     kidx;
  logic           which;
  logic [19:0]    y;
  logic [31:0]    acc;
  logic           acc_one;
  logic [3:0]     idx;
  logic [EB-1:0]  eased_r;
  logic signed [29:0] pacc;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [EB-1:0] base, prev;
  logic [63:0] pow_rnd, exp_rnd;
  logic [32:0] acc33;
  logic [4:0]  shamt;
  logic [33:0] exp_val;
  logic [20:0] y_next;
  logic        lo;
  logic [20:0] raw;
  logic [EB-1:0] value;
  logic signed [10:0] diff;
  logic signed [29:0] pacc_next;

  function automatic logic [20:0] comp(input logic [20:0] x);
    return (x >= 21'(ecpg_pkg::FIX_ONE)) ? 21'd0 : 21'(ecpg_pkg::FIX_ONE) - x;
  endfunction

  // multiplier operand selection
  always_comb begin
    base  = step[2] ? u : {1'b0, t};
    prev  = (step[1:0] == 2'd0) ? base : pw[step - 3'd1];
    mul_a = '0;
    mul_b = '0;
    if (state == ST_EXP) begin
      mul_a = acc;
      mul_b = ecpg_pkg::EXP_COEF[kidx];
    end else begin
      mul_a = 32'(prev);
      mul_b = 32'(base);
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign pow_rnd = mul_p + 64'(ecpg_pkg::FIX_HALF);
  assign exp_rnd = mul_p + (64'd1 << 31);

  assign acc33   = acc_one ? 33'h1_0000_0000 : {1'b0, acc};
  assign shamt   = 5'(ecpg_pkg::FRAC_BITS) + {1'b0, y[19:16]};
  assign exp_val = ({1'b0, acc33} + (34'd1 << (shamt - 5'd1))) >> shamt;
  // 10*u for the first exp2 pass, 10*t loaded at its end for the second
  assign y_next  = (state == ST_EXPFIN) ? ({4'd0, t, 1'b0} + {2'd0, t, 3'd0})
                                        : ({3'd0, u, 1'b0} + {1'b0, u, 3'd0});

  // curve value select
  assign lo = (t < ecpg_pkg::FIX_HALF);
  always_comb begin
    case (ecpg_pkg::curve_t'(idx))
      ecpg_pkg::CRV_LINEAR:      raw = 21'(t);
      ecpg_pkg::CRV_IN_QUAD:     raw = 21'(pw[0]);
      ecpg_pkg::CRV_OUT_QUAD:    raw = comp(21'(pw[4]));
      ecpg_pkg::CRV_INOUT_QUAD:  raw = lo ? 21'(pw[0]) << 1 : comp(21'(pw[4]) << 1);
      ecpg_pkg::CRV_IN_CUBIC:    raw = 21'(pw[1]);
      ecpg_pkg::CRV_OUT_CUBIC:   raw = comp(21'(pw[5]));
      ecpg_pkg::CRV_INOUT_CUBIC: raw = lo ? 21'(pw[1]) << 2 : comp(21'(pw[5]) << 2);
      ecpg_pkg::CRV_IN_QUART:    raw = 21'(pw[2]);
      ecpg_pkg::CRV_OUT_QUART:   raw = comp(21'(pw[6]));
      ecpg_pkg::CRV_IN_EXPO:     raw = (t == '0) ? 21'd0 : 21'(ex[0]);
      ecpg_pkg::CRV_OUT_EXPO:    raw = comp(21'(ex[1]));
      ecpg_pkg::CRV_IN_QUINT:    raw = 21'(pw[3]);
      ecpg_pkg::CRV_OUT_QUINT:   raw = comp(21'(pw[7]));
      ecpg_pkg::CRV_INOUT_QUINT: raw = lo ? 21'(pw[3]) << 4 : comp(21'(pw[7]) << 4);
      default:                   raw = 21'd0;
    endcase
    value = (raw > 21'(ecpg_pkg::FIX_ONE)) ? ecpg_pkg::FIX_ONE : raw[EB-1:0];
  end

  assign diff = $signed({1'b0, span.end_pos}) - $signed({1'b0, span.start_pos});
  assign pacc_next = $signed({4'd0, span.start_pos, 16'd0})
                   + 30'($signed({1'b0, eased_r})) * 30'(diff)
                   + $signed(30'(ecpg_pkg::FIX_HALF));

  assign q_pop = (state == ST_IDLE) & ~q_empty;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        t <= q_data;
        u <= ecpg_pkg::FIX_ONE - {1'b0, q_data};
      end
      ST_POW: pw[step] <= pow_rnd[ecpg_pkg::FRAC_BITS +: EB];
      ST_EXPFIN: ex[which] <= exp_val[EB-1:0];
      ST_SEL: eased_r <= value;
      ST_POS: pacc <= pacc_next;
      default: ;
    endcase
    if (state == ST_EXP && y[15 - kidx]) begin
      acc <= acc_one ? ecpg_pkg::EXP_COEF[kidx] : exp_rnd[63:32];
    end
    if ((state == ST_POW && step == 3'd7) || state == ST_EXPFIN) begin
      y <= y_next[19:0];
    end
    if (state == ST_POS) begin
      curve <= idx;
      eased <= eased_r;
      last  <= (idx == ecpg_pkg::CRV_INOUT_QUINT);
    end
    if (state == ST_HOLD && !out_valid) begin
      if (pacc < 0) begin
        position <= '0;
      end else if (pacc[29:16] > 14'(2**ecpg_pkg::POS_BITS - 1)) begin
        position <= '1;
      end else begin
        position <= pacc[16 +: ecpg_pkg::POS_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      kidx      <= '0;
      which     <= 1'b0;
      acc_one   <= 1'b1;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            step  <= '0;
            which <= 1'b0;
            state <= ST_POW;
          end
        end
        ST_POW: begin
          step <= step + 3'd1;
          if (step == 3'd7) begin
            kidx    <= '0;
            acc_one <= 1'b1;
            state   <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (y[15 - kidx]) acc_one <= 1'b0;
          kidx <= kidx + 4'd1;
          if (kidx == 4'd15) state <= ST_EXPFIN;
        end
        ST_EXPFIN: begin
          kidx    <= '0;
          acc_one <= 1'b1;
          which   <= 1'b1;
          if (which) begin
            idx   <= '0;
            state <= ST_SEL;
          end else begin
            state <= ST_EXP;
          end
        end
        ST_SEL: state <= ST_POS;
        ST_POS: state <= ST_HOLD;
        ST_HOLD: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            idx       <= idx + 4'd1;
            state     <= (idx == ecpg_pkg::CRV_INOUT_QUINT) ? ST_IDLE : ST_SEL;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/easing_curve_position_generator_top.sv
// ----------------------------------------------------------------------------
// easing_curve_position_generator_top: easing curve position generator
// Per tick advances a Q0.16 phase and emits fourteen eased positions.
// ----------------------------------------------------------------------------
// sequencing: the shared multiplier forms 8 powers, then two 16-step exp2
//   passes; each word then goes through select, position and hold states
//   and waits for a ready consumer; the next tick is started only after
//   the last word, with up to two more ticks held in the queue
// reset: synchronous, clears phase, queue and sequencer; registers return to
//   start 10, end 990, step 328
module easing_curve_position_generator_top (
  input  logic        clk,
  input  logic        rst,
  // tick channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        tick,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  curve,
  output logic [16:0] eased,
  output logic [9:0]  position,
  output logic        last
);

  // phase queue between front and back
  logic                           q_push;
  logic                           q_pop;
  logic                           q_full;
  logic                           q_empty;
  logic [ecpg_pkg::FRAC_BITS-1:0] q_wdata;
  logic [ecpg_pkg::FRAC_BITS-1:0] q_rdata;
  ecpg_pkg::span_t                span;

  // front: takes ticks, keeps phase and the configuration registers
  ecpg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tick      (tick),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .span      (span)
  );

  // short queue so ticks can be taken while curves are still being sent
  ecpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: evaluates the curves and drives the result words
  ecpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .span      (span),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .curve     (curve),
    .eased     (eased),
    .position  (position),
    .last      (last)
  );

endmodule

FILE: rtl/ecpg_checker.sv
// ----------------------------------------------------------------------------
// ecpg_checker: port-level checks
// Watches the top level's ports and flags protocol and range slips.
// ----------------------------------------------------------------------------
module ecpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  curve,
  input logic [16:0] eased,
  input logic        last
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(curve) && $stable(eased))
    else $error("stalled word changed");

  // last flag marks the final curve only
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (curve == ecpg_pkg::CRV_INOUT_QUINT)))
    else $error("last flag on wrong curve");

  // eased value never above one
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> eased <= 17'(ecpg_pkg::FIX_ONE))
    else $error("eased value out of range");

  // a word with a curve index beyond the list is never shown
  a_curve: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> curve <= ecpg_pkg::CRV_INOUT_QUINT)
    else $error("curve index out of range");

endmodule

bind easing_curve_position_generator_top ecpg_checker u_ecpg_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .curve     (curve),
  .eased     (eased),
  .last      (last)
);

FILE: tb/easing_curve_position_generator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// easing curve position generator testbench
// Drives ticks in bursts, predicts all fourteen eased values and positions
// per tick and checks every result word in order, across several settings.
// ----------------------------------------------------------------------------
module easing_curve_position_generator_top_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        tick = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  curve;
  logic [16:0] eased;
  logic [9:0]  position;
  logic        last;

  easing_curve_position_generator_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .tick(tick),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .curve(curve), .eased(eased), .position(position), .last(last)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [3:0]  curve;
    logic [16:0] eased;
    logic [9:0]  position;
    logic        last;
  } word_t;

  // predictor state, own copy of the block's registers
  logic [63:0] pr_phase, pr_start, pr_end, pr_step;

  logic  tick_q[$];        // pending tick words for the driver
  word_t curve_words_q[$]; // expected result words
  int    errors = 0;
  int    idle_cycles = 0;
  bit    hold_sender = 1'b0;
  int    hold_off = 0;     // long receiver stall, counted in its own process
  int    pending_ticks;

  // rounded fixed-point product
  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'd32768) >> 16;
  endfunction

  function automatic logic [63:0] fx_pow(logic [63:0] x, int k);
    logic [63:0] r;
    r = x;
    for (int i = 1; i < k; i++) r = fx_mul(r, x);
    return r;
  endfunction

  function automatic logic [63:0] one_minus(logic [63:0] x);
    return (x >= 64'd65536) ? 64'd0 : 64'd65536 - x;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^-y, y with 16 fraction bits
  function automatic logic [63:0] pow2_neg(logic [63:0] y);
    logic [63:0] n, f, acc, c, s;
    n = y >> 16;
    f = y & 64'hFFFF;
    acc = 64'd1 << 32;
    c = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      c = root64(c << 32);
      if ((f >> (16 - k)) & 1) acc = (acc * c + (64'd1 << 31)) >> 32;
    end
    s = 16 + n;
    if (s > 62) return 0;
    return (acc + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [63:0] ease_value(ecpg_pkg::curve_t c, logic [63:0] t);
    logic [63:0] u;
    bit lo;
    u = 64'd65536 - t;
    lo = t < 64'd32768;
    case (c)
      ecpg_pkg::CRV_LINEAR:      return t;
      ecpg_pkg::CRV_IN_QUAD:     return fx_pow(t, 2);
      ecpg_pkg::CRV_OUT_QUAD:    return one_minus(fx_pow(u, 2));
      ecpg_pkg::CRV_INOUT_QUAD:
        return lo ? 2 * fx_pow(t, 2) : one_minus(2 * fx_pow(u, 2));
      ecpg_pkg::CRV_IN_CUBIC:    return fx_pow(t, 3);
      ecpg_pkg::CRV_OUT_CUBIC:   return one_minus(fx_pow(u, 3));
      ecpg_pkg::CRV_INOUT_CUBIC:
        return lo ? 4 * fx_pow(t, 3) : one_minus(4 * fx_pow(u, 3));
      ecpg_pkg::CRV_IN_QUART:    return fx_pow(t, 4);
      ecpg_pkg::CRV_OUT_QUART:   return one_minus(fx_pow(u, 4));
      ecpg_pkg::CRV_IN_EXPO:     return (t == 0) ? 64'd0 : pow2_neg(10 * u);
      ecpg_pkg::CRV_OUT_EXPO:    return one_minus(pow2_neg(10 * t));
      ecpg_pkg::CRV_IN_QUINT:    return fx_pow(t, 5);
      ecpg_pkg::CRV_OUT_QUINT:   return one_minus(fx_pow(u, 5));
      default:         return lo ? 16 * fx_pow(t, 5) : one_minus(16 * fx_pow(u, 5));
    endcase
  endfunction

  function automatic logic [9:0] place_position(logic [63:0] e);
    longint d, acc;
    d = longint'(pr_end) - longint'(pr_start);
    acc = longint'(pr_start * 65536) + longint'(e) * d + 32768;
    if (acc < 0) return 10'd0;
    acc = acc >>> 16;
    return (acc > 1023) ? 10'd1023 : acc[9:0];
  endfunction

  // advance the phase and queue the fourteen expected words
  task automatic predict_tick(logic t);
    logic [63:0] sum, e;
    word_t w;
    if (!t) return;
    sum = pr_phase + pr_step;
    pr_phase = (sum >= 64'd65536) ? 64'd0 : sum;
    for (int i = 0; i < 14; i++) begin
      e = ease_value(ecpg_pkg::curve_t'(i), pr_phase);
      if (e > 64'd65536) e = 64'd65536;
      w.curve = i[3:0];
      w.eased = e[16:0];
      w.position = place_position(e);
      w.last = (i == 13);
      curve_words_q.push_back(w);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: bursts of random length with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_tick(tick);
        void'(tick_q.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold the word
      end else if (hold_sender || tick_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        tick <= tick_q[0];
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200);
        end
      end
    end
  end

  // receiver: own stall pattern, plus the long hold-off
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    word_t w;
    if (!rst && out_valid && out_ready) begin
      if (curve_words_q.size() == 0) begin
        report_mismatch("unexpected word, curve", curve, -1);
      end else begin
        w = curve_words_q.pop_front();
        if (curve !== w.curve) report_mismatch("curve", curve, w.curve);
        if (eased !== w.eased) report_mismatch("eased", eased, w.eased);
        if (position !== w.position) report_mismatch("position", position, w.position);
        if (last !== w.last) report_mismatch("last", last, w.last);
      end
    end
  end

  // watchdog on cycles with no word accepted on any channel, outside reset and the long hold-off
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || hold_off > 0 || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || curve_words_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(ecpg_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      ecpg_pkg::REG_START_POS:  pr_start = val & 16'h3FF;
      ecpg_pkg::REG_END_POS:    pr_end = val & 16'h3FF;
      ecpg_pkg::REG_PHASE_STEP: pr_step = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_ticks(int n, int low_pct);
    for (int i = 0; i < n; i++) tick_q.push_back($urandom_range(0, 99) >= low_pct);
  endtask

  initial begin
    pr_phase = 0; pr_start = 10; pr_end = 990; pr_step = 328;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, two ticks with a tick low word between them
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);
    wait_drained();

    // large step crosses one and wraps, reverse span to zero
    write_reg(ecpg_pkg::REG_START_POS, 16'd1023);
    write_reg(ecpg_pkg::REG_END_POS, 16'd0);
    write_reg(ecpg_pkg::REG_PHASE_STEP, 16'hFFFF);
    add_ticks(3, 0);
    wait_drained();

    // half step hits the inOut midpoint, full span
    write_reg(ecpg_pkg::REG_START_POS, 16'd0);
    write_reg(ecpg_pkg::REG_END_POS, 16'd1023);
    write_reg(ecpg_pkg::REG_PHASE_STEP, 16'h8000);
    add_ticks(4, 0);
    wait_drained();

    // zero step holds the phase, then the minimum step
    write_reg(ecpg_pkg::REG_PHASE_STEP, 16'd0);
    add_ticks(2, 0);
    wait_drained();
    write_reg(ecpg_pkg::REG_PHASE_STEP, 16'd1);
    write_reg(ecpg_pkg::REG_UNUSED, 16'hFFFF);
    add_ticks(3, 0);
    wait_drained();

    // random phases with random settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ecpg_pkg::REG_START_POS, $urandom_range(0, 1023));
      write_reg(ecpg_pkg::REG_END_POS, $urandom_range(0, 1023));
      write_reg(ecpg_pkg::REG_PHASE_STEP,
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                            : $urandom_range(1, 8000));
      if (ph == 2) begin
        // long receiver stall while ticks keep coming
        hold_off = 3000;
        add_ticks(30, 0);
      end else begin
        add_ticks(25, 10);
      end
      if (ph == 5) begin
        // sender pauses until every expected word is out
        while (tick_q.size() > 12) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || curve_words_q.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    pending_ticks = curve_words_q.size();
    if (errors == 0 && pending_ticks == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
